@@ sv/nmea_gga_field_extractor_defines.svh @@
// Assertion macros shared by the NMEA GGA field extractor modules.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_DEFINES_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NGFE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NGFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ngfe_pkg.sv @@
// Package with the types, constants and step tables of the NMEA GGA field extractor.
package ngfe_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int WP_W       = $clog2(LINE_DEPTH + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] KIND_TIME = 2'd0;
  localparam logic [1:0] KIND_LAT  = 2'd1;
  localparam logic [1:0] KIND_LON  = 2'd2;

  // Header check: five bytes of "GPGGA", then the first latitude byte.
  localparam logic [2:0] CHK_LAST  = 3'd5;
  localparam logic [4:0] EMIT_LAST = 5'd28;

  localparam logic [ADDR_W-1:0] ADDR_TIME = ADDR_W'(6);
  localparam logic [ADDR_W-1:0] ADDR_LAT  = ADDR_W'(16);
  localparam logic [ADDR_W-1:0] ADDR_LATT = ADDR_W'(27);
  localparam logic [ADDR_W-1:0] ADDR_LON  = ADDR_W'(29);
  localparam logic [ADDR_W-1:0] ADDR_LONT = ADDR_W'(41);

  typedef struct packed {
    logic       put;
    logic       restart;
    logic [7:0] data;
  } st_cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        index;
    logic [ADDR_W-1:0] addr;
    logic              first;
    logic              tail;
  } step_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] j);
    logic [7:0] c;
    unique case (j)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h47;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] chk_addr(input logic [2:0] j);
    return (j == CHK_LAST) ? ADDR_LAT : ADDR_W'(j);
  endfunction

  // Maps result number 0..28 to its field, position and store address.
  function automatic step_t step_info(input logic [4:0] k);
    step_t s;
    logic [4:0] i;
    s = '0;
    if (k < 5'd6) begin
      i       = k;
      s.kind  = KIND_TIME;
      s.index = i[3:0];
      s.addr  = ADDR_TIME + ADDR_W'(i);
      s.first = (i == 5'd0);
      s.tail  = 1'b0;
    end else if (k < 5'd17) begin
      i       = k - 5'd6;
      s.kind  = KIND_LAT;
      s.index = i[3:0];
      s.addr  = (i < 5'd10) ? ADDR_LAT + ADDR_W'(i) : ADDR_LATT;
      s.first = (i == 5'd0);
      s.tail  = (i == 5'd10);
    end else begin
      i       = k - 5'd17;
      s.kind  = KIND_LON;
      s.index = i[3:0];
      s.addr  = (i < 5'd11) ? ADDR_LON + ADDR_W'(i) : ADDR_LONT;
      s.first = (i == 5'd0);
      s.tail  = (i == 5'd11);
    end
    return s;
  endfunction

endpackage

@@ sv/ngfe_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module ngfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/ngfe_line_store.sv @@
// Line store: byte RAM, per-entry valid bits and the saturating write position.
`include "nmea_gga_field_extractor_defines.svh"

module ngfe_line_store (
  input  logic              clk,
  input  logic              rst,
  input  ngfe_pkg::st_cmd_t cmd,
  input  ngfe_pkg::rd_req_t rd_req,
  output logic [7:0]        rd_data
);

  logic [ngfe_pkg::WP_W-1:0]       wp;
  logic [ngfe_pkg::LINE_DEPTH-1:0] valid_bits;
  logic                            rd_valid;
  logic [7:0]                      ram_q;
  logic                            full;
  logic                            do_write;

  assign full     = (wp == ngfe_pkg::WP_W'(ngfe_pkg::LINE_DEPTH));
  assign do_write = cmd.put && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (cmd.restart) begin
        wp <= '0;
      end else if (do_write) begin
        wp <= wp + 1'b1;
      end
      if (do_write) begin
        valid_bits[wp[ngfe_pkg::ADDR_W-1:0]] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_valid <= valid_bits[rd_req.addr];
      end
    end
  end

  ngfe_ram #(
    .WIDTH(8),
    .DEPTH(ngfe_pkg::LINE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(wp[ngfe_pkg::ADDR_W-1:0]),
    .wdata(cmd.data),
    .re   (rd_req.en),
    .raddr(rd_req.addr),
    .rdata(ram_q)
  );

  // Entries never written since reset read as zero.
  assign rd_data = rd_valid ? ram_q : 8'h00;

  `NGFE_ASSERT_NOW(a_wp_range, clk, rst, 1'b1, wp <= ngfe_pkg::WP_W'(ngfe_pkg::LINE_DEPTH), "write position beyond store")

endmodule

@@ sv/ngfe_seq.sv @@
// Sentence-end sequencer: header check, field readout and the result register.
`include "nmea_gga_field_extractor_defines.svh"

module ngfe_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output ngfe_pkg::rd_req_t         rd_req,
  input  logic [7:0]                rd_data,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                field_kind,
  output logic [3:0]                char_index,
  output logic [7:0]                char_value,
  output logic                      run_last
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHK_RD    = 3'd1;
  localparam logic [2:0] S_CHK_WT    = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_WT   = 3'd4;
  localparam logic [2:0] S_EMIT_HOLD = 3'd5;

  logic [2:0]      state;
  logic [2:0]      chk_idx;
  logic [4:0]      emit_idx;
  logic            digit_ok;
  logic            seen_zero;
  ngfe_pkg::step_t step;
  logic            span_zero;
  logic [7:0]      value;

  assign step      = ngfe_pkg::step_info(emit_idx);
  assign span_zero = step.first ? 1'b0 : seen_zero;
  assign busy      = (state != S_IDLE);

  always_comb begin
    if (step.kind != ngfe_pkg::KIND_TIME && !digit_ok) begin
      value = 8'h00;
    end else if (step.tail) begin
      value = rd_data;
    end else if (span_zero) begin
      value = 8'h00;
    end else begin
      value = rd_data;
    end
  end

  always_comb begin
    rd_req.en   = 1'b0;
    rd_req.addr = step.addr;
    if (state == S_CHK_RD) begin
      rd_req.en   = 1'b1;
      rd_req.addr = ngfe_pkg::chk_addr(chk_idx);
    end else if (state == S_EMIT_RD) begin
      rd_req.en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_idx   <= '0;
      emit_idx  <= '0;
      digit_ok  <= 1'b0;
      seen_zero <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            chk_idx <= '0;
            state   <= S_CHK_RD;
          end
        end
        S_CHK_RD: begin
          state <= S_CHK_WT;
        end
        S_CHK_WT: begin
          if (chk_idx == ngfe_pkg::CHK_LAST) begin
            digit_ok <= (rd_data >= ngfe_pkg::CH_ZERO) && (rd_data <= ngfe_pkg::CH_NINE);
            emit_idx <= '0;
            state    <= S_EMIT_RD;
          end else if (rd_data != ngfe_pkg::hdr_char(chk_idx)) begin
            state <= S_IDLE;
          end else begin
            chk_idx <= chk_idx + 1'b1;
            state   <= S_CHK_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WT;
        end
        S_EMIT_WT: begin
          if (!step.tail) begin
            seen_zero <= span_zero || (rd_data == 8'h00);
          end
          out_valid <= 1'b1;
          state     <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (emit_idx == ngfe_pkg::EMIT_LAST) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_WT) begin
      field_kind <= step.kind;
      char_index <= step.index;
      char_value <= value;
      run_last   <= (emit_idx == ngfe_pkg::EMIT_LAST);
    end
  end

  `NGFE_ASSERT_NOW(a_last_pos, clk, rst, out_valid && run_last, field_kind == ngfe_pkg::KIND_LON && char_index == 4'd11, "last result is not the final longitude character")
  `NGFE_ASSERT_NEXT(a_idle_after_last, clk, rst, out_valid && !out_stall && run_last, !busy && !out_valid, "block not idle after the last result")
  `NGFE_ASSERT_NOW(a_no_digit_zero, clk, rst, out_valid && !digit_ok && field_kind != ngfe_pkg::KIND_TIME, char_value == 8'h00, "position field not zero without a leading digit")
  `NGFE_ASSERT_NOW(a_idle_empty, clk, rst, !busy, !out_valid, "result pending while idle")

endmodule

@@ sv/nmea_gga_field_extractor.sv @@
// Top level of the NMEA GGA field extractor.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_stall   rx_byte
//   output   out        out_valid / out_stall field_kind, char_index, char_value, run_last
//
// An ordinary byte is written to the line store; a '$' restarts the write position.
// A carriage return starts the readout; the input is stalled until it is done.
// The header check reads up to six store bytes and ends the readout at the first
// header mismatch; otherwise each of the 29 results passes a RAM read, a data
// state and the output register, and is held there while the output is stalled.
// Reset clears the write position, the per-entry valid bits and all control state;
// entries never written read as zero, so no clearing pass is needed.
// The input is stalled while reset is high.
// A stalled result is held in the output register until it is taken.
module nmea_gga_field_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] field_kind,
  output logic [3:0] char_index,
  output logic [7:0] char_value,
  output logic       run_last
);

  logic              in_accept;
  logic              busy;
  logic              start;
  ngfe_pkg::st_cmd_t cmd;
  ngfe_pkg::rd_req_t rd_req;
  logic [7:0]        rd_data;

  // The sequencer owns the store's read port from a carriage return until the
  // header check fails or the last result is taken, so input items wait in that
  // time. No item is taken while the block is held in reset.
  assign in_stall  = rst || busy;
  assign in_accept = in_valid && !in_stall;

  assign start       = in_accept && (rx_byte == ngfe_pkg::CH_CR);
  assign cmd.restart = in_accept && (rx_byte == ngfe_pkg::CH_DOLLAR);
  assign cmd.put     = in_accept && (rx_byte != ngfe_pkg::CH_DOLLAR)
                       && (rx_byte != ngfe_pkg::CH_CR);
  assign cmd.data    = rx_byte;

  ngfe_line_store u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .rd_req (rd_req),
    .rd_data(rd_data)
  );

  ngfe_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .field_kind(field_kind),
    .char_index(char_index),
    .char_value(char_value),
    .run_last  (run_last)
  );

endmodule
